FILE: rtl/core/prfe_pkg.sv
// Package for the planar rectangle fill engine: screen geometry, store sizing,
// operation codes and the pixel bit ordering helper. Depends on nothing else.
package prfe_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int NUM_PLANES    = 4;
   localparam int WORD_W        = 32;
   localparam int WORDS_PER_ROW = (SCREEN_WIDTH + WORD_W - 1) / WORD_W;
   localparam int PLANE_WORDS   = WORDS_PER_ROW * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(PLANE_WORDS);

   // Field widths of the request and response words.
   localparam int OP_W    = 2;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 4;
   localparam int PLANE_W = 2;
   localparam int INDEX_W = 14;

   typedef enum logic [OP_W-1:0] {
      OP_FILL    = 2'd0,
      OP_OUTLINE = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // Maps a mask in column order onto the stored bit layout: the first column
   // of each byte is its most significant bit, bytes are little endian.
   function automatic logic [WORD_W-1:0] vga_bit_order(input logic [WORD_W-1:0] col_mask);
      logic [WORD_W-1:0] res;
      logic [4:0]        pos;
      res = '0;
      for (int c = 0; c < WORD_W; c++) begin
         pos = 5'(c);
         res[{pos[4:3], ~pos[2:0]}] = col_mask[c];
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/planar_rect_fill_engine.sv
// Planar rectangle fill engine: sequencer, packed four plane frame store and
// response register. Depends on prfe_pkg.
//
// Usage. A request word on req_* carries an operation: fill a rectangle, draw
// the outline of a rectangle, or read one 32-bit word of one plane. Every
// request gives exactly one response word on rsp_*: rsp_status is 1 only for
// a fill whose start lies off the screen, and rsp_read_data carries the plane
// word of a read and is zero otherwise.
// Sequence. The store keeps all four planes of one word side by side, so each
// covered word is updated by one read and one write of the single store port.
// Each rectangle has a setup step (an outline is four rectangles, a fill one),
// and every item has an accept step before and a finish step after its work.
// The engine holds req_stall high while it works on an item, one at a time.
// Reset. After reset a clearing pass writes zero into every store word, one
// word per cycle, WORDS_PER_ROW * SCREEN_HEIGHT words (9600 at 640x480);
// req_stall stays high until the pass ends.
// Stalls. A finished response waits in its output register while rsp_stall is
// high; the engine takes and works the next request meanwhile, and only holds
// its own completion until the register is free.
module planar_rect_fill_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [prfe_pkg::OP_W-1:0]            req_operation,
   input  logic [prfe_pkg::COORD_W-1:0]         req_start_x,
   input  logic [prfe_pkg::COORD_W-1:0]         req_start_y,
   input  logic [prfe_pkg::COORD_W-1:0]         req_rect_width,
   input  logic [prfe_pkg::COORD_W-1:0]         req_rect_height,
   input  logic [prfe_pkg::COLOR_W-1:0]         req_color,
   input  logic [prfe_pkg::PLANE_W-1:0]         req_plane_select,
   input  logic [prfe_pkg::INDEX_W-1:0]         req_word_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [prfe_pkg::WORD_W-1:0]          rsp_read_data
);
   import prfe_pkg::*;

   // Coordinates after adding width or height need one more bit.
   localparam int EXT_W  = COORD_W + 1;
   localparam int WCOL_W = EXT_W - 5;
   localparam int STORE_W = NUM_PLANES * WORD_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_READ,
      S_WRITE,
      S_RDADDR,
      S_RDDATA,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [COORD_W-1:0]       x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic [PLANE_W-1:0]       plane_ff, plane_in;
   logic [INDEX_W-1:0]       index_ff, index_in;
   logic [1:0]               sub_ff, sub_in;
   logic [COORD_W-1:0]       row_ff, row_in, y_last_ff, y_last_in;
   logic [WCOL_W-1:0]        wc_ff, wc_in, wc_first_ff, wc_first_in, wc_last_ff, wc_last_in;
   logic [4:0]               lo_ff, lo_in, last_bit_ff, last_bit_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic                     res_status_ff, res_status_in;
   logic [WORD_W-1:0]        res_data_ff, res_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]        rsp_data_ff, rsp_data_in;

   // Frame store: one entry holds the same word of all four planes.
   logic [STORE_W-1:0]       mem [PLANE_WORDS];
   logic [STORE_W-1:0]       rd_ff;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_addr;
   logic [STORE_W-1:0]       mem_wdata;

   // Current rectangle of the item, before clipping.
   logic [EXT_W-1:0]         sx, sy;
   logic [COORD_W-1:0]       sw, sh;
   logic                     start_in_screen, rect_empty;
   logic [EXT_W:0]           x_sum, y_sum;
   logic [EXT_W-1:0]         x_end, y_end, x_last, y_end_m1;

   // Per word mask and merge.
   logic [4:0]               lo_eff, last_eff;
   logic [WORD_W-1:0]        col_mask, bit_mask;
   logic                     rect_last;
   logic                     index_ok;

   always_comb begin
      sx = {1'b0, x_ff};
      sy = {1'b0, y_ff};
      sw = w_ff;
      sh = h_ff;
      if (op_ff != OP_FILL) begin
         case (sub_ff)
            2'd0: begin
               sh = COORD_W'(1);
            end
            2'd1: begin
               sw = COORD_W'(1);
            end
            2'd2: begin
               sx = EXT_W'(x_ff) + EXT_W'(w_ff);
               sw = COORD_W'(1);
            end
            default: begin
               sy = EXT_W'(y_ff) + EXT_W'(h_ff);
               sh = COORD_W'(1);
            end
         endcase
      end
   end

   always_comb begin
      start_in_screen = (sx < EXT_W'(SCREEN_WIDTH)) && (sy < EXT_W'(SCREEN_HEIGHT));
      rect_empty      = (sw == '0) || (sh == '0);
      x_sum    = (EXT_W+1)'(sx) + (EXT_W+1)'(sw);
      y_sum    = (EXT_W+1)'(sy) + (EXT_W+1)'(sh);
      x_end    = (x_sum > (EXT_W+1)'(SCREEN_WIDTH)) ? EXT_W'(SCREEN_WIDTH) : x_sum[EXT_W-1:0];
      y_end    = (y_sum > (EXT_W+1)'(SCREEN_HEIGHT)) ? EXT_W'(SCREEN_HEIGHT) : y_sum[EXT_W-1:0];
      x_last   = x_end - EXT_W'(1);
      y_end_m1 = y_end - EXT_W'(1);
   end

   // Columns of the current word that the rectangle covers.
   always_comb begin
      lo_eff   = (wc_ff == wc_first_ff) ? lo_ff : 5'd0;
      last_eff = (wc_ff == wc_last_ff) ? last_bit_ff : 5'd31;
      for (int c = 0; c < WORD_W; c++) begin
         col_mask[c] = (5'(c) >= lo_eff) && (5'(c) <= last_eff);
      end
      bit_mask  = vga_bit_order(col_mask);
      rect_last = (op_ff == OP_FILL) || (sub_ff == 2'd3);
      index_ok  = 32'(index_ff) < PLANE_WORDS;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = ADDR_W'(32'(row_ff) * WORDS_PER_ROW + 32'(wc_ff));
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         S_WRITE: begin
            mem_we = 1'b1;
            for (int p = 0; p < NUM_PLANES; p++) begin
               mem_wdata[p*WORD_W +: WORD_W] = (rd_ff[p*WORD_W +: WORD_W] & ~bit_mask)
                                             | (color_ff[p] ? bit_mask : '0);
            end
         end
         S_RDADDR: begin
            mem_addr = ADDR_W'(index_ff);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      color_in      = color_ff;
      plane_in      = plane_ff;
      index_in      = index_ff;
      sub_in        = sub_ff;
      row_in        = row_ff;
      y_last_in     = y_last_ff;
      wc_in         = wc_ff;
      wc_first_in   = wc_first_ff;
      wc_last_in    = wc_last_ff;
      lo_in         = lo_ff;
      last_bit_in   = last_bit_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(PLANE_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_operation;
               x_in          = req_start_x;
               y_in          = req_start_y;
               w_in          = req_rect_width;
               h_in          = req_rect_height;
               color_in      = req_color;
               plane_in      = req_plane_select;
               index_in      = req_word_index;
               sub_in        = 2'd0;
               res_status_in = 1'b0;
               res_data_in   = '0;
               case (req_operation)
                  OP_FILL, OP_OUTLINE: begin
                     state_in = S_SETUP;
                  end
                  OP_READ: begin
                     state_in = S_RDADDR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SETUP: begin
            row_in      = sy[COORD_W-1:0];
            y_last_in   = y_end_m1[COORD_W-1:0];
            wc_in       = sx[EXT_W-1:5];
            wc_first_in = sx[EXT_W-1:5];
            wc_last_in  = x_last[EXT_W-1:5];
            lo_in       = sx[4:0];
            last_bit_in = x_last[4:0];
            if (!start_in_screen && (op_ff == OP_FILL)) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else if (!start_in_screen || rect_empty) begin
               if (rect_last) begin
                  state_in = S_DONE;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_READ;
            if (wc_ff != wc_last_ff) begin
               wc_in = wc_ff + WCOL_W'(1);
            end else if (row_ff != y_last_ff) begin
               row_in = row_ff + COORD_W'(1);
               wc_in  = wc_first_ff;
            end else if (rect_last) begin
               state_in = S_DONE;
            end else begin
               sub_in   = sub_ff + 2'd1;
               state_in = S_SETUP;
            end
         end
         S_RDADDR: begin
            state_in = S_RDDATA;
         end
         S_RDDATA: begin
            res_data_in = index_ok ? rd_ff[32'(plane_ff) * WORD_W +: WORD_W] : '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // The response register is free once its last word has been taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      color_ff      <= color_in;
      plane_ff      <= plane_in;
      index_ff      <= index_in;
      sub_ff        <= sub_in;
      row_ff        <= row_in;
      y_last_ff     <= y_last_in;
      wc_ff         <= wc_in;
      wc_first_ff   <= wc_first_in;
      wc_last_ff    <= wc_last_in;
      lo_ff         <= lo_in;
      last_bit_ff   <= last_bit_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

`ifndef SYNTHESIS
   // Every word that the sweep updates has at least one covered column.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (col_mask != '0))
      else $error("store update with an empty column mask");

   // The sweep never leaves the clipped rectangle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ((row_ff <= y_last_ff) && (wc_ff <= wc_last_ff)
                                && (32'(row_ff) < SCREEN_HEIGHT)))
      else $error("sweep position outside the clipped rectangle");

   // Store writes stay inside one plane.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_addr) < PLANE_WORDS))
      else $error("store write beyond the plane");

   // A new response word appears only on completion of an item.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) && (state_ff != S_DONE) |=> !rsp_valid_ff)
      else $error("response word without a completed item");
`endif

endmodule
